[hdl/text_console_char_writer_defines.svh]
// Assertion macros for the console writer's RTL.
// No dependencies; the user module must have aclk and aresetn in scope.
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define TCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

[hdl/tcw_pkg.sv]
// Types and fixed constants of the text console character writer.
// No dependencies.
package tcw_pkg;

    localparam int CELL_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;

    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] BLANK_CHAR = 8'h20;

    localparam logic [3:0] RESET_FG = 4'd10;
    localparam logic [3:0] RESET_BG = 4'd0;
    localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_BG, RESET_FG, BLANK_CHAR};

    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'd1;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_READ   = 4'b0100,
        S_SCROLL = 4'b1000
    } state_t;

endpackage

[hdl/tcw_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/text_console_char_writer.sv]
// Text console character writer: screen store, cursor and control codes.
// Depends on tcw_pkg, tcw_ram and text_console_char_writer_defines.svh.
// A put item's result is registered on acceptance; a read item's waits for the RAM data,
// registered in S_READ. A put that scrolls runs S_SCROLL, where the single write port of
// the screen RAM moves and blanks one cell per cycle. Throughput: one put item per cycle
// when the result side keeps up and no scroll runs; a read holds off the next item.
// Reset (aresetn low, synchronous) clears the cursor and registers, then a clearing pass
// blanks the RAM; no item is accepted until it ends.
module text_console_char_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcw_pkg::CFG_DAT_W-1:0]   cfg_wdata,
    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // char_code[7:0], cell_index[18:8], zero
    input  logic [0:0]                      s_tuser,   // op[0]
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata    // cell_data[15:0], cursor_pos[26:16],
                                                       // scrolled[27], zero
);

    import tcw_pkg::*;

    `include "text_console_char_writer_defines.svh"

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int NW = $clog2(CELL_COUNT + 1);
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam int TW = $clog2(COLUMNS + TAB_STOP + 1);

    // Control and cursor state.
    state_t          state_reg, state_next;
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [3:0]      fg_reg, bg_reg;
    logic            rd_ok_reg;

    // Result register.
    logic            m_valid_reg;
    logic [15:0]     out_data_reg;
    logic [10:0]     out_pos_reg;
    logic            out_scr_reg;

    // RAM port signals.
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [15:0]     ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [15:0]     ram_rdata;

    logic            accept;
    logic            in_op;
    logic [7:0]      in_char;
    logic [10:0]     in_idx;
    logic            in_range;
    logic [7:0]      attr;

    // Put decode.
    logic            put_we;
    logic            put_bs;
    logic            new_line;
    logic            scroll_start;
    logic [15:0]     put_data;
    logic [CW:0]     col_inc;
    logic [TW-1:0]   tab_tbl [COLUMNS];
    logic [TW-1:0]   tab_next;
    logic [RW-1:0]   w_row;
    logic [CW-1:0]   w_col;
    logic [31:0]     put_addr32;
    logic [31:0]     cur_pos32;
    logic [31:0]     next_pos32;
    logic [31:0]     scroll_rd32;
    logic [NW-1:0]   cnt_m1;

    assign in_op    = s_tuser[0];
    assign in_char  = s_tdata[7:0];
    assign in_idx   = s_tdata[18:8];
    assign in_range = 32'(in_idx) < 32'(CELL_COUNT);
    assign attr     = {bg_reg, fg_reg};

    // A new item is only taken in S_IDLE, once the result register is free or is being emptied now.
    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Column reached by a tab from each starting column, worked out at elaboration.
    for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
        assign tab_tbl[g] = TW'((g / TAB_STOP + 1) * TAB_STOP);
    end

    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign tab_next = tab_tbl[col_reg];

    // Effect of a put item on the cursor and on the screen store.
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        new_line = 1'b0;
        put_we   = 1'b0;
        put_bs   = 1'b0;
        put_data = {attr, in_char};
        case (in_char)
            CHAR_LF: begin
                new_line = 1'b1;
            end
            CHAR_CR: begin
                col_next = '0;
            end
            CHAR_TAB: begin
                if (32'(tab_next) >= 32'(COLUMNS)) begin
                    new_line = 1'b1;
                end else begin
                    col_next = tab_next[CW-1:0];
                end
            end
            CHAR_BS: begin
                // Backspace steps back, wrapping to the end of the previous row; at the
                // top left corner the cursor stays and that cell is still blanked.
                put_we   = 1'b1;
                put_bs   = 1'b1;
                put_data = {attr, BLANK_CHAR};
                if (col_reg != '0) begin
                    col_next = col_reg - 1'b1;
                end else if (row_reg != '0) begin
                    row_next = row_reg - 1'b1;
                    col_next = CW'(COLUMNS - 1);
                end
            end
            default: begin
                put_we = 1'b1;
                if (32'(col_inc) >= 32'(COLUMNS)) begin
                    new_line = 1'b1;
                end else begin
                    col_next = col_inc[CW-1:0];
                end
            end
        endcase
        scroll_start = 1'b0;
        if (new_line) begin
            col_next = '0;
            if (32'(row_reg) == 32'(ROWS - 1)) begin
                scroll_start = 1'b1;
            end else begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    // Backspace writes at the cell it moves to; a printable character at the old cursor.
    assign w_row      = put_bs ? row_next : row_reg;
    assign w_col      = put_bs ? col_next : col_reg;
    assign put_addr32 = 32'(w_row) * 32'(COLUMNS) + 32'(w_col);
    assign cur_pos32  = 32'(row_reg) * 32'(COLUMNS) + 32'(col_reg);
    assign next_pos32 = 32'(row_next) * 32'(COLUMNS) + 32'(col_next);

    // Scroll sweep: in step n the cell one row below n is read and, one step later, the
    // value that came back is written one row up; the last row's steps write blanks.
    assign cnt_m1      = cnt_reg - 1'b1;
    assign scroll_rd32 = 32'(cnt_reg) + 32'(COLUMNS);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = put_addr32[AW-1:0];
        ram_wdata = put_data;
        ram_raddr = in_range ? AW'(in_idx) : '0;
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = RESET_BLANK;
            end
            S_IDLE: begin
                ram_we = accept && !in_op && put_we;
            end
            S_SCROLL: begin
                ram_we    = cnt_reg != '0;
                ram_waddr = cnt_m1[AW-1:0];
                ram_wdata = (32'(cnt_m1) < 32'(MOVE_COUNT)) ? ram_rdata : {attr, BLANK_CHAR};
                ram_raddr = (scroll_rd32 < 32'(CELL_COUNT)) ? scroll_rd32[AW-1:0] : '0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_CLEAR: begin
                if (32'(cnt_reg) == 32'(CELL_COUNT - 1)) begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (in_op) begin
                        state_next = S_READ;
                    end else if (scroll_start) begin
                        state_next = S_SCROLL;
                        cnt_next   = '0;
                    end
                end
            end
            S_READ: begin
                state_next = S_IDLE;
            end
            S_SCROLL: begin
                if (32'(cnt_reg) == 32'(CELL_COUNT)) begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            fg_reg      <= RESET_FG;
            bg_reg      <= RESET_BG;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            if (cfg_we) begin
                case (cfg_index)
                    REG_FOREGROUND: fg_reg <= cfg_wdata;
                    REG_BACKGROUND: bg_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (accept && !in_op) begin
                row_reg <= row_next;
                col_reg <= col_next;
                if (!scroll_start) begin
                    m_valid_reg <= 1'b1;
                end
            end

            // Read data and the end of a scroll complete the pending result.
            if (state_reg == S_READ) begin
                m_valid_reg <= 1'b1;
            end
            if ((state_reg == S_SCROLL) && (32'(cnt_reg) == 32'(CELL_COUNT))) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // Result payload: set up at acceptance; the read data joins in the cycle after, in S_READ.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_ok_reg    <= in_range;
            out_data_reg <= '0;
            out_scr_reg  <= !in_op && scroll_start;
            out_pos_reg  <= in_op ? cur_pos32[10:0] : next_pos32[10:0];
        end
        if (state_reg == S_READ) begin
            out_data_reg <= rd_ok_reg ? ram_rdata : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, out_scr_reg, out_pos_reg, out_data_reg};

    `TCW_ASSERT(a_no_take_while_blocked, (m_tvalid && !m_tready) |-> !s_tready, "item taken while the result is stalled")
    `TCW_ASSERT(a_no_write_in_read, (state_reg == S_READ) |-> !ram_we, "screen written while a read is pending")
    `TCW_ASSERT(a_scroll_cursor, (m_tvalid && m_tdata[27]) |-> (m_tdata[26:16] == 11'((ROWS - 1) * COLUMNS)), "scroll result with cursor off the bottom row")
    `TCW_ASSERT(a_scroll_done, ((state_reg == S_SCROLL) && (32'(cnt_reg) == 32'(CELL_COUNT))) |=> ((state_reg == S_IDLE) && m_tvalid), "scroll did not complete its result")
    `TCW_ASSERT(a_cursor_bounds, (32'(row_reg) < 32'(ROWS)) && (32'(col_reg) < 32'(COLUMNS)), "cursor outside the screen")

endmodule
